/* design/sha256_block_compression_macros.svh */
// assertion macros for the sha-256 compression block
`ifndef SHA256_BLOCK_COMPRESSION_MACROS_SVH
`define SHA256_BLOCK_COMPRESSION_MACROS_SVH

// implication checked at every clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* design/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, opcodes and round constants of the sha-256 compression block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw    = 2;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_MSG  = 1'b1
   } opcode_type;

   // one command from front to back
   typedef struct packed {
      logic        is_load;
      logic [2:0]  index;
      logic [31:0] data;
      logic        block_end;
      logic        last;
   } cmd_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

/* design/sha_front.sv */
// ----------------------------------------------------------------------------
// sha_front
// accepts items, counts message words and queues commands for the core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_opcode,
   input  logic [2:0]       req_word_index,
   input  logic [31:0]      req_data_word,
   input  logic             req_last_block,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output sha_pkg::cmd_type cmd
);
   import sha_pkg::*;

   cmd_type                cmd_mem [QueueDepth];
   logic [QueueAw-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QueueAw:0]       fill_ff, fill_in;
   logic [3:0]             count_ff, count_in;
   logic                   push_ok, is_msg;
   cmd_type                new_cmd;

   assign push_ok  = req_push && !req_full;
   assign req_full = (fill_ff == QueueAw'(0) + (QueueAw+1)'(QueueDepth));
   assign is_msg   = (opcode_type'(req_opcode) == OP_MSG);

   always_comb begin
      new_cmd.is_load   = !is_msg;
      new_cmd.index     = req_word_index;
      new_cmd.data      = req_data_word;
      new_cmd.block_end = is_msg && (count_ff == 4'd15);
      new_cmd.last      = req_last_block;
   end

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_ok) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
         if (is_msg) count_in = count_ff + 4'd1;
      end
      if (cmd_take) rd_ptr_in = rd_ptr_ff + 1'b1;
      if (push_ok && !cmd_take) fill_in = fill_ff + 1'b1;
      else if (!push_ok && cmd_take) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) cmd_mem[wr_ptr_ff] <= new_cmd;
   end

   assign cmd_valid = (fill_ff != '0);
   assign cmd       = cmd_mem[rd_ptr_ff];

endmodule

/* design/sha_core.sv */
// ----------------------------------------------------------------------------
// sha_core
// chaining words, block buffer, 64-round engine and digest output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  sha_pkg::cmd_type cmd,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_digest_index,
   output logic             rsp_last_word
);
   import sha_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ROUND = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] hash_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];     // sliding schedule window, w_ff[0] is w[t]
   logic [5:0]  round_ff;
   logic [3:0]  wcnt_ff;
   logic        last_ff;
   logic [2:0]  emit_ff;
   logic        out_valid_ff;
   logic [31:0] out_word_ff;
   logic [2:0]  out_index_ff;
   logic        out_last_ff;
   logic        out_free;

   logic [31:0] s0, s1, w_next, big0, big1, ch, maj, t1, t2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   assign out_free = !out_valid_ff || rsp_pop;
   assign cmd_take = cmd_valid && (state_ff == ST_IDLE);

   always_comb begin
      s0     = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1     = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_next = w_ff[0] + s0 + w_ff[9] + s1;
      big1   = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch     = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1     = v_ff[7] + big1 + ch + round_k(round_ff) + w_ff[0];
      big0   = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj    = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2     = big0 + maj;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (cmd_take && !cmd.is_load && cmd.block_end) state_in = ST_ROUND;
         ST_ROUND: if (round_ff == 6'd63) state_in = last_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT:  if (out_free && emit_ff == 3'd7) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         wcnt_ff      <= '0;
         round_ff     <= '0;
         emit_ff      <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         // output register refills only while emitting
         if (out_free) out_valid_ff <= (state_ff == ST_EMIT);
         case (state_ff)
            ST_IDLE: begin
               if (cmd_take) begin
                  if (cmd.is_load) begin
                     hash_ff[cmd.index] <= cmd.data;
                  end else begin
                     wcnt_ff <= wcnt_ff + 4'd1;
                     if (cmd.block_end) begin
                        for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
                        last_ff  <= cmd.last;
                        round_ff <= '0;
                        emit_ff  <= '0;
                     end
                  end
               end
            end
            ST_ROUND: begin
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) begin
                  hash_ff[0] <= hash_ff[0] + t1 + t2;
                  for (int i = 1; i < 8; i++) begin
                     if (i == 4) hash_ff[i] <= hash_ff[i] + v_ff[3] + t1;
                     else        hash_ff[i] <= hash_ff[i] + v_ff[i-1];
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  emit_ff <= emit_ff + 3'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers without reset
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd_take && !cmd.is_load) begin
         w_ff[wcnt_ff] <= cmd.data;
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_next;
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
      if (state_ff == ST_EMIT && out_free) begin
         out_word_ff  <= hash_ff[emit_ff];
         out_index_ff <= emit_ff;
         out_last_ff  <= (emit_ff == 3'd7);
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_digest_word  = out_word_ff;
   assign rsp_digest_index = out_index_ff;
   assign rsp_last_word    = out_last_ff;

endmodule

/* design/sha256_block_compression.sv */
// ----------------------------------------------------------------------------
// sha256_block_compression
// sha-256 compression of 16-word blocks with chaining words kept across blocks
// ----------------------------------------------------------------------------
//  channel   ports                                          direction
//  request   req_push/req_full, opcode, word_index, data    in
//  response  rsp_pop/rsp_empty, digest_word/index/last      out
//
// a load or non-final message word is taken by the core whenever it is idle
// the sixteenth word runs 64 rounds, one per cycle, in the shared round unit;
// while the rounds run, the core takes no further items
// a final block then emits eight words, one per cycle when popped
// reset clears chaining words and counters; a 4-entry queue absorbs input stalls
`timescale 1ns / 1ps

module sha256_block_compression (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_opcode,
   input  logic [2:0]  req_word_index,
   input  logic [31:0] req_data_word,
   input  logic        req_last_block,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_last_word
);
   import sha_pkg::*;

   logic    cmd_valid, cmd_take;
   cmd_type cmd;

   sha_front u_front (
      .clock, .reset, .req_push, .req_full, .req_opcode, .req_word_index,
      .req_data_word, .req_last_block, .cmd_valid, .cmd_take, .cmd
   );

   sha_core u_core (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd, .rsp_empty, .rsp_pop,
      .rsp_digest_word, .rsp_digest_index, .rsp_last_word
   );

endmodule

/* design/sha_checker.sv */
// ----------------------------------------------------------------------------
// sha_checker
// port-level checks of the sha-256 compression block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha256_block_compression_macros.svh"

module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_digest_index,
   input logic        rsp_last_word
);
   `SHA_ASSERT_IMP(a_last_on_h, clock, reset, !rsp_empty |-> (rsp_last_word == (rsp_digest_index == 3'd7)), "last flag off word h")
   `SHA_ASSERT_NEXT(a_index_step, clock, reset, !rsp_empty && rsp_pop && !rsp_last_word, rsp_empty || rsp_digest_index == $past(rsp_digest_index) + 3'd1, "digest index skipped")
   `SHA_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_digest_word), "stalled item changed")
   `SHA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty && !req_full, "not empty after reset")
endmodule

bind sha256_block_compression sha_checker u_sha_checker (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_digest_word,
   .rsp_digest_index, .rsp_last_word
);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// checks the sha-256 compression block against its own round-by-round predictor,
// using directed loads and blocks, then random well-formed and broken sequences
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import sha_pkg::*;

   typedef struct {
      opcode_type  op;
      logic [2:0]  idx;
      logic [31:0] data;
      logic        last;
   } req_item_t;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        last;
   } digest_t;

   localparam int unsigned StallLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_opcode = 1'b0;
   logic [2:0]  req_word_index = 3'd0;
   logic [31:0] req_data_word = 32'd0;
   logic        req_last_block = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_digest_index;
   logic        rsp_last_word;

   sha256_block_compression DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   req_item_t   pending_items[$];
   digest_t     expected_digests[$];
   logic [31:0] hash_state[8];
   logic [31:0] msg_block[16];
   int unsigned msg_count;
   int unsigned fail_count;
   int unsigned idle_cycles;
   bit          stimulus_done;
   bit          hold_off;

   localparam logic [31:0] RoundK[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_msg_block();
      logic [31:0] sched[64];
      logic [31:0] v[8];
      logic [31:0] t1;
      logic [31:0] t2;
      for (int i = 0; i < 16; i++) sched[i] = msg_block[i];
      for (int i = 16; i < 64; i++)
         sched[i] = sched[i-16] + sched[i-7]
                  + (ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3))
                  + (ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + sched[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int j = 7; j > 0; j--) v[j] = v[j-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
   endtask

   // predicts the digest words caused by one accepted item
   task automatic predict_digest(input req_item_t it);
      digest_t d;
      if (it.op == OP_LOAD) begin
         hash_state[it.idx] = it.data;
      end else begin
         msg_block[msg_count] = it.data;
         msg_count = (msg_count + 1) % 16;
         if (msg_count == 0) begin
            compress_msg_block();
            if (it.last) begin
               for (int k = 0; k < 8; k++) begin
                  d.word = hash_state[k];
                  d.idx  = 3'(k);
                  d.last = (k == 7);
                  expected_digests.push_back(d);
               end
            end
         end
      end
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic req_item_t make_item(input opcode_type op, input logic [2:0] idx,
                                           input logic [31:0] data, input logic last);
      req_item_t it;
      it.op = op; it.idx = idx; it.data = data; it.last = last;
      return it;
   endfunction

   // one block of 16 message words; flag noise on the first fifteen
   task automatic queue_block(input logic last, input int pattern);
      logic [31:0] w;
      for (int i = 0; i < 16; i++) begin
         case (pattern)
            0: w = 32'h0;
            1: w = 32'hffffffff;
            default: w = $urandom;
         endcase
         pending_items.push_back(make_item(OP_MSG, 3'($urandom), w,
                                           (i == 15) ? last : 1'($urandom)));
      end
   endtask

   task automatic queue_loads(input int pattern);
      for (int k = 0; k < 8; k++)
         pending_items.push_back(make_item(OP_LOAD, 3'(k),
            (pattern == 0) ? 32'h0 : (pattern == 1) ? 32'hffffffff : $urandom,
            1'($urandom)));
   endtask

   initial begin
      // final block straight from reset, then extremes of the loaded state
      queue_block(1'b1, 0);
      queue_loads(1);
      queue_block(1'b1, 1);
      queue_loads(0);
      // non-final block followed by a final one, with a load in mid-block
      queue_block(1'b0, 2);
      for (int i = 0; i < 7; i++)
         pending_items.push_back(make_item(OP_MSG, 3'd7, $urandom, 1'b1));
      pending_items.push_back(make_item(OP_LOAD, 3'd3, 32'h80000001, 1'b1));
      for (int i = 0; i < 9; i++)
         pending_items.push_back(make_item(OP_MSG, 3'd0, $urandom, i == 8));
      while (pending_items.size() < 280) begin
         case ($urandom_range(0, 9))
            0, 1:    queue_loads(2);
            2:       pending_items.push_back(make_item(OP_LOAD, 3'($urandom), $urandom,
                                                       1'($urandom)));
            3:       pending_items.push_back(make_item(OP_MSG, 3'($urandom), $urandom,
                                                       1'($urandom)));
            4:       queue_block(1'b0, 2);
            default: queue_block(1'b1, $urandom_range(0, 9) == 0 ? 1 : 2);
         endcase
      end
   end

   initial begin
      for (int i = 0; i < 8; i++) hash_state[i] = 32'h0;
      msg_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   int unsigned send_wait;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) predict_digest(make_item(opcode_type'(req_opcode),
            req_word_index, req_data_word, req_last_block));
         if (req_push && req_full) begin
            // keep offering the same item
         end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            req_push <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_item_t it;
            it = pending_items.pop_front();
            req_push <= 1'b1;
            req_opcode <= it.op;
            req_word_index <= it.idx;
            req_data_word <= it.data;
            req_last_block <= it.last;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         end else begin
            req_push <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // long hold-off of the receiver so the input side backs up
   int unsigned cycle_count;
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         hold_off    <= (cycle_count >= 300 && cycle_count < 1300);
      end
   end

   // monitor and receiver
   int unsigned pop_wait;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_digests.size() == 0) begin
               report("unexpected word", rsp_digest_word, 32'h0);
            end else begin
               digest_t d;
               d = expected_digests.pop_front();
               if (rsp_digest_word !== d.word) report("digest_word", rsp_digest_word, d.word);
               if (rsp_digest_index !== d.idx)
                  report("digest_index", 32'(rsp_digest_index), 32'(d.idx));
               if (rsp_last_word !== d.last)
                  report("last_word", 32'(rsp_last_word), 32'(d.last));
            end
            pop_wait <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
            rsp_pop <= 1'b0;
         end else if (hold_off) begin
            rsp_pop <= 1'b0;
         end else if (pop_wait > 0) begin
            pop_wait <= pop_wait - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog and end of run
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("status: fail");
            $finish;
         end
         if (stimulus_done && expected_digests.size() == 0) begin
            repeat (200) @(posedge clock);
            if (fail_count == 0 && expected_digests.size() == 0 && rsp_empty) begin
               $display("status: pass");
            end else begin
               if (!rsp_empty) report("extra word", rsp_digest_word, 32'h0);
               if (expected_digests.size() != 0) report("missing words", 0, 0);
               $display("status: fail");
            end
            $finish;
         end
      end
   end

endmodule
